### sv/lge_pkg.sv
// Shared constants and codes for the Life generation engine.
package lge_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);

    // Fixed widths of the request and configuration fields.
    localparam int FUNC_W     = 2;
    localparam int CELL_ROW_W = 7;
    localparam int CELL_COL_W = 8;
    localparam int GW_W       = 9;
    localparam int GH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Reset values of the configuration registers.
    localparam logic [GW_W-1:0] GRID_WIDTH_RST  = GW_W'(100);
    localparam logic [GH_W-1:0] GRID_HEIGHT_RST = GH_W'(40);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_WRAP_EDGES  = 2'd2
    } t_cfg_idx;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_READ  = 2'd2
    } t_func;

    typedef logic [MAX_COLS-1:0] t_row;

endpackage

### sv/life_generation_engine.sv
// Top level of the Life generation engine: grid storage, sequencer and neighbor unit.
//
// The block keeps two banks of MAX_ROWS rows, each row MAX_COLS cells wide, in one
// row-wide memory with a single read and a single write port, and a one-bit bank
// select. A cell write or read passes through a row read, then the update or bit pick,
// since a write is a read-modify-write of its row. A generation step walks every row
// of the largest grid: a row outside the active area is written dead, and an active
// row takes three row reads through the one read port into a window of above, own
// and below rows, then one cell per cycle through the shared neighbor-count unit,
// then one row write into the other bank. The block takes no new request until the
// current one has produced its result; the result waits in an output register.
// Cells never written since reset read as undefined.
module life_generation_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [lge_pkg::FUNC_W-1:0]      i_func,
    input  logic [lge_pkg::CELL_ROW_W-1:0]  i_cell_row,
    input  logic [lge_pkg::CELL_COL_W-1:0]  i_cell_col,
    input  logic                            i_cell_value,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_read_value,
    output logic                            o_converged,
    // Configuration
    input  logic                            i_cfg_we,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lge_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import lge_pkg::*;

    localparam int ADDR_W = ROW_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCESS,
        S_ROW,
        S_RD1,
        S_RD2,
        S_RD3,
        S_CELL,
        S_WRITE,
        S_FINISH
    } t_state;

    // Control and configuration
    t_state              r_state, n_state;
    logic                r_cur, n_cur;
    logic [GW_W-1:0]     r_grid_width;
    logic [GH_W-1:0]     r_grid_height;
    logic                r_wrap;
    logic                r_out_valid, n_out_valid;

    // Payload
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [COL_W-1:0]    r_col, n_col;
    logic                r_val, n_val;
    logic                r_same, n_same;
    logic                r_res_read, n_res_read;
    logic                r_res_conv, n_res_conv;
    logic                r_read_value, n_read_value;
    logic                r_converged, n_converged;
    t_row                r_up, n_up;
    t_row                r_mid, n_mid;
    t_row                r_dn, n_dn;
    t_row                r_nrow, n_nrow;

    // Grid memory: entry {bank, row}
    t_row                r_grid [2*MAX_ROWS];
    t_row                r_rd_data;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_ra;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wa;
    t_row                mem_wd;

    // Effective grid size and neighbor indexes
    logic [GW_W-1:0]     eff_w;
    logic [GH_W-1:0]     eff_h;
    logic [COL_W-1:0]    last_col;
    logic [ROW_W-1:0]    last_row;
    logic                row_active;
    logic                row_is_last;
    logic [ROW_W-1:0]    up_idx, dn_idx;
    logic                up_ok, dn_ok, up_self, dn_self;
    logic [COL_W-1:0]    l_idx, rt_idx;
    logic                l_ok, rt_ok, l_self, rt_self;
    logic [3:0]          nb_cnt;
    logic                cell_self;
    logic                cell_next;
    logic                in_accept;
    logic                req_hit;
    t_row                rmw_row;

    always_comb begin
        if (r_grid_width == '0) begin
            eff_w = GW_W'(1);
        end else if (r_grid_width > GW_W'(MAX_COLS)) begin
            eff_w = GW_W'(MAX_COLS);
        end else begin
            eff_w = r_grid_width;
        end
        if (r_grid_height == '0) begin
            eff_h = GH_W'(1);
        end else if (r_grid_height > GH_W'(MAX_ROWS)) begin
            eff_h = GH_W'(MAX_ROWS);
        end else begin
            eff_h = r_grid_height;
        end
    end

    assign last_col    = COL_W'(eff_w - GW_W'(1));
    assign last_row    = ROW_W'(eff_h - GH_W'(1));
    assign row_active  = (GH_W'(r_row) < eff_h);
    assign row_is_last = (r_row == ROW_W'(MAX_ROWS - 1));

    // Row neighbors, wrapped onto the torus when enabled.
    assign up_idx  = (r_row == '0) ? last_row : r_row - ROW_W'(1);
    assign up_ok   = (r_row != '0) || r_wrap;
    assign dn_idx  = (r_row == last_row) ? '0 : r_row + ROW_W'(1);
    assign dn_ok   = (r_row != last_row) || r_wrap;
    assign up_self = up_ok && (up_idx == r_row);
    assign dn_self = dn_ok && (dn_idx == r_row);

    // Column neighbors of the cell under evaluation.
    assign l_idx   = (r_col == '0) ? last_col : r_col - COL_W'(1);
    assign l_ok    = (r_col != '0) || r_wrap;
    assign rt_idx  = (r_col == last_col) ? '0 : r_col + COL_W'(1);
    assign rt_ok   = (r_col != last_col) || r_wrap;
    assign l_self  = l_ok && (l_idx == r_col);
    assign rt_self = rt_ok && (rt_idx == r_col);

    // Shared neighbor unit. A wrapped position that lands on the cell itself is
    // skipped; rows outside the grid are already zero in the window.
    always_comb begin
        nb_cnt = 4'(r_up[l_idx]  & l_ok  & ~(up_self & l_self))
               + 4'(r_up[r_col]          & ~up_self)
               + 4'(r_up[rt_idx] & rt_ok & ~(up_self & rt_self))
               + 4'(r_mid[l_idx] & l_ok  & ~l_self)
               + 4'(r_mid[rt_idx] & rt_ok & ~rt_self)
               + 4'(r_dn[l_idx]  & l_ok  & ~(dn_self & l_self))
               + 4'(r_dn[r_col]          & ~dn_self)
               + 4'(r_dn[rt_idx] & rt_ok & ~(dn_self & rt_self));
        cell_self = r_mid[r_col];
        cell_next = (nb_cnt == 4'd3) || (cell_self && (nb_cnt == 4'd2));
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign req_hit   = (GH_W'(i_cell_row) < eff_h) && (GW_W'(i_cell_col) < eff_w);

    always_comb begin
        rmw_row        = r_rd_data;
        rmw_row[r_col] = r_val;
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_out_valid  = r_out_valid;
        n_func       = r_func;
        n_row        = r_row;
        n_col        = r_col;
        n_val        = r_val;
        n_same       = r_same;
        n_res_read   = r_res_read;
        n_res_conv   = r_res_conv;
        n_read_value = r_read_value;
        n_converged  = r_converged;
        n_up         = r_up;
        n_mid        = r_mid;
        n_dn         = r_dn;
        n_nrow       = r_nrow;
        mem_re       = 1'b0;
        mem_ra       = {r_cur, r_row};
        mem_we       = 1'b0;
        mem_wa       = {~r_cur, r_row};
        mem_wd       = r_nrow;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_func     = i_func;
                    n_row      = ROW_W'(i_cell_row);
                    n_col      = COL_W'(i_cell_col);
                    n_val      = i_cell_value;
                    n_res_read = 1'b0;
                    n_res_conv = 1'b0;
                    case (t_func'(i_func))
                        FUNC_WRITE, FUNC_READ: begin
                            if (req_hit) begin
                                mem_re  = 1'b1;
                                mem_ra  = {r_cur, ROW_W'(i_cell_row)};
                                n_state = S_ACCESS;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                        FUNC_STEP: begin
                            n_row   = '0;
                            n_same  = 1'b1;
                            n_state = S_ROW;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_ACCESS: begin
                if (r_func == FUNC_WRITE) begin
                    mem_we = 1'b1;
                    mem_wa = {r_cur, r_row};
                    mem_wd = rmw_row;
                end else begin
                    n_res_read = r_rd_data[r_col];
                end
                n_state = S_FINISH;
            end
            S_ROW: begin
                if (row_active) begin
                    mem_re  = 1'b1;
                    mem_ra  = {r_cur, up_idx};
                    n_state = S_RD1;
                end else begin
                    // Rows below the active area are written dead.
                    mem_we = 1'b1;
                    mem_wd = '0;
                    if (row_is_last) begin
                        n_cur      = ~r_cur;
                        n_res_conv = r_same;
                        n_state    = S_FINISH;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end
            end
            S_RD1: begin
                mem_re  = 1'b1;
                mem_ra  = {r_cur, r_row};
                n_up    = up_ok ? r_rd_data : '0;
                n_state = S_RD2;
            end
            S_RD2: begin
                mem_re  = 1'b1;
                mem_ra  = {r_cur, dn_idx};
                n_mid   = r_rd_data;
                n_state = S_RD3;
            end
            S_RD3: begin
                n_dn    = dn_ok ? r_rd_data : '0;
                n_col   = '0;
                n_nrow  = '0;
                n_state = S_CELL;
            end
            S_CELL: begin
                n_nrow[r_col] = cell_next;
                if (cell_next != cell_self) begin
                    n_same = 1'b0;
                end
                if (r_col == last_col) begin
                    n_state = S_WRITE;
                end else begin
                    n_col = r_col + COL_W'(1);
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
                if (row_is_last) begin
                    n_cur      = ~r_cur;
                    n_res_conv = r_same;
                    n_state    = S_FINISH;
                end else begin
                    n_row   = r_row + ROW_W'(1);
                    n_state = S_ROW;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_read_value = r_res_read;
                    n_converged  = r_res_conv;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_wrap        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GRID_WIDTH:  r_grid_width  <= GW_W'(i_cfg_data);
                    CFG_GRID_HEIGHT: r_grid_height <= GH_W'(i_cfg_data);
                    CFG_WRAP_EDGES:  r_wrap        <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_func       <= n_func;
        r_row        <= n_row;
        r_col        <= n_col;
        r_val        <= n_val;
        r_same       <= n_same;
        r_res_read   <= n_res_read;
        r_res_conv   <= n_res_conv;
        r_read_value <= n_read_value;
        r_converged  <= n_converged;
        r_up         <= n_up;
        r_mid        <= n_mid;
        r_dn         <= n_dn;
        r_nrow       <= n_nrow;
    end

    // Grid memory: one row write and one registered row read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_grid[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rd_data <= r_grid[mem_ra];
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_converged  = r_converged;

endmodule
